// ----- src/wds_pkg.sv -----
// Shared types, constants and helpers for the wall distance stencil.
`timescale 1ns / 1ps
package wds_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned DIST_W      = 32;
  localparam int unsigned SQ_W        = 2 * DIST_W;
  localparam int unsigned REM_W       = DIST_W + 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned SQRT_STEPS  = 2;
  localparam int unsigned SQRT_STAGES = DIST_W / SQRT_STEPS;
  localparam int unsigned PRE_STAGES  = 4;
  localparam int unsigned NUM_STAGES  = PRE_STAGES + SQRT_STAGES + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_ENABLES = 3'd0,
    REG_CELLS_X      = 3'd1,
    REG_CELLS_Y      = 3'd2,
    REG_CELLS_Z      = 3'd3,
    REG_THREE_DIM    = 3'd4,
    REG_STEP_X_LIMIT = 3'd5,
    REG_STEP_Y_LIMIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic             inf;
    logic [IDX_W-1:0] cnt;
  } axis_sel_t;

  function automatic logic [IDX_W-1:0] abs_diff(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic axis_sel_t axis_select(input logic lo_en, input logic hi_en,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [IDX_W-1:0] size);
    axis_sel_t r;
    logic [IDX_W-1:0] to_hi;
    to_hi = abs_diff(size, idx);
    r.inf = 1'b0;
    r.cnt = idx;
    if (lo_en && hi_en) begin
      r.cnt = ({idx, 1'b0} <= {1'b0, size}) ? idx : to_hi;
    end else if (lo_en) begin
      r.cnt = idx;
    end else if (hi_en) begin
      r.cnt = to_hi;
    end else begin
      r.inf = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] sat_mul(input logic [IDX_W-1:0] cnt,
                                                input logic [DIST_W-1:0] w);
    logic [IDX_W+DIST_W-1:0] p;
    p = {{DIST_W{1'b0}}, cnt} * {{IDX_W{1'b0}}, w};
    return (|p[IDX_W+DIST_W-1:DIST_W]) ? DIST_MAX : p[DIST_W-1:0];
  endfunction

endpackage

// ----- src/wds_if.sv -----
// Handshake channels: cell words, result words and register writes.
`timescale 1ns / 1ps
interface wds_item_if;
  logic                       valid;
  logic                       ready;
  logic [wds_pkg::IDX_W-1:0]  cell_i;
  logic [wds_pkg::IDX_W-1:0]  cell_j;
  logic [wds_pkg::IDX_W-1:0]  cell_k;
  logic                       is_obstacle;
  logic [wds_pkg::DIST_W-1:0] width_x;
  logic [wds_pkg::DIST_W-1:0] width_y;
  logic [wds_pkg::DIST_W-1:0] width_z;
  modport source (output valid, cell_i, cell_j, cell_k, is_obstacle,
                  width_x, width_y, width_z, input ready);
  modport sink (input valid, cell_i, cell_j, cell_k, is_obstacle,
                width_x, width_y, width_z, output ready);
endinterface

interface wds_result_if;
  logic                       valid;
  logic                       ready;
  logic [wds_pkg::DIST_W-1:0] wall_dist;
  modport source (output valid, wall_dist, input ready);
  modport sink (input valid, wall_dist, output ready);
endinterface

interface wds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wds_pkg::CFG_IDX_W-1:0]  index;
  logic [wds_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/wall_distance_stencil.sv -----
// Top level: pipelined nearest-wall distance per grid cell.
//
// Cell words enter on in_i, one result word per cell leaves on out_o, both
// valid/ready. Register writes arrive on cfg_i (index, data) and are always
// taken; write them only while no cell is in flight.
// A cell passes from acceptance to the result word through four
// front stages (index select, axis products, squares, sum of squares),
// a 16-stage square root resolving two root bits per stage, and the output
// register. Throughput: one cell per clock while out_o is ready. Each
// stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up. When the receiver stalls, words pile up
// stage by stage and in_i.ready falls only once the whole pipeline holds
// words; nothing is lost. Reset clears all valid bits and loads the register
// defaults: all six faces are walls, 64 cells per axis, 2D mode, backward step disabled.
`timescale 1ns / 1ps
module wall_distance_stencil (
  input  logic       clk_i,
  input  logic       rst_ni,
  wds_item_if.sink   in_i,
  wds_result_if.source out_o,
  wds_cfg_if.sink    cfg_i
);

  localparam int unsigned NS  = wds_pkg::NUM_STAGES;
  localparam int unsigned NQ  = wds_pkg::SQRT_STAGES;
  localparam int unsigned SQB = wds_pkg::PRE_STAGES;

  logic [5:0]                 wall_en_q;
  logic [wds_pkg::IDX_W-1:0]  cells_x_q, cells_y_q, cells_z_q;
  logic                       three_dim_q;
  logic [wds_pkg::IDX_W-1:0]  step_x_q, step_y_q;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_en_q   <= 6'd63;
      cells_x_q   <= 10'd64;
      cells_y_q   <= 10'd64;
      cells_z_q   <= 10'd64;
      three_dim_q <= 1'b0;
      step_x_q    <= '0;
      step_y_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        wds_pkg::REG_WALL_ENABLES: wall_en_q   <= cfg_i.data[5:0];
        wds_pkg::REG_CELLS_X:      cells_x_q   <= cfg_i.data;
        wds_pkg::REG_CELLS_Y:      cells_y_q   <= cfg_i.data;
        wds_pkg::REG_CELLS_Z:      cells_z_q   <= cfg_i.data;
        wds_pkg::REG_THREE_DIM:    three_dim_q <= cfg_i.data[0];
        wds_pkg::REG_STEP_X_LIMIT: step_x_q    <= cfg_i.data;
        wds_pkg::REG_STEP_Y_LIMIT: step_y_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || out_o.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_i.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // stage 0: pick cell counts
  wds_pkg::axis_sel_t         ax_d, ay_d, az_d;
  wds_pkg::axis_sel_t         ax_q, ay_q, az_q;
  logic [wds_pkg::IDX_W-1:0]  ovx_d, ovy_d, dj_d, di_d;
  logic [wds_pkg::IDX_W-1:0]  ovx_q, ovy_q, dj_q, di_q;
  logic [wds_pkg::DIST_W-1:0] wx_q, wy_q, wz_q;
  logic                       obst0_q, step0_q;

  always_comb begin
    ax_d = wds_pkg::axis_select(wall_en_q[0], wall_en_q[1], in_i.cell_i, cells_x_q);
    ay_d = wds_pkg::axis_select(wall_en_q[2], wall_en_q[3], in_i.cell_j, cells_y_q);
    az_d = wds_pkg::axis_select(wall_en_q[4], wall_en_q[5], in_i.cell_k, cells_z_q);
    az_d.inf = az_d.inf || !three_dim_q;
    ovx_d = (in_i.cell_i > step_x_q) ? (in_i.cell_i - step_x_q) : '0;
    ovy_d = (in_i.cell_j > step_y_q) ? (in_i.cell_j - step_y_q) : '0;
    dj_d  = wds_pkg::abs_diff(in_i.cell_j, step_y_q);
    di_d  = wds_pkg::abs_diff(in_i.cell_i, step_x_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax_q <= ax_d; ay_q <= ay_d; az_q <= az_d;
      ovx_q <= ovx_d; ovy_q <= ovy_d; dj_q <= dj_d; di_q <= di_d;
      wx_q <= in_i.width_x; wy_q <= in_i.width_y; wz_q <= in_i.width_z;
      obst0_q <= in_i.is_obstacle;
      step0_q <= (step_x_q != '0) && (step_y_q != '0);
    end
  end

  // stage 1: axis and edge products
  logic [wds_pkg::DIST_W-1:0] dx_q, dy_q, dz_q, ta_q, tb_q, la_q, lb_q;
  logic                       obst1_q, step1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_q <= ax_q.inf ? wds_pkg::DIST_MAX : wds_pkg::sat_mul(ax_q.cnt, wx_q);
      dy_q <= ay_q.inf ? wds_pkg::DIST_MAX : wds_pkg::sat_mul(ay_q.cnt, wy_q);
      dz_q <= az_q.inf ? wds_pkg::DIST_MAX : wds_pkg::sat_mul(az_q.cnt, wz_q);
      ta_q <= wds_pkg::sat_mul(ovx_q, wx_q);
      tb_q <= wds_pkg::sat_mul(dj_q, wy_q);
      la_q <= wds_pkg::sat_mul(di_q, wx_q);
      lb_q <= wds_pkg::sat_mul(ovy_q, wy_q);
      obst1_q <= obst0_q;
      step1_q <= step0_q;
    end
  end

  // stage 2: squares and axis minimum
  logic [wds_pkg::SQ_W-1:0]   ta2_q, tb2_q, la2_q, lb2_q;
  logic                       tinf2_q, linf2_q, obst2_q, step2_q;
  logic [wds_pkg::DIST_W-1:0] dmin2_q, dxy;

  assign dxy = (dx_q < dy_q) ? dx_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ta2_q <= {{wds_pkg::DIST_W{1'b0}}, ta_q} * {{wds_pkg::DIST_W{1'b0}}, ta_q};
      tb2_q <= {{wds_pkg::DIST_W{1'b0}}, tb_q} * {{wds_pkg::DIST_W{1'b0}}, tb_q};
      la2_q <= {{wds_pkg::DIST_W{1'b0}}, la_q} * {{wds_pkg::DIST_W{1'b0}}, la_q};
      lb2_q <= {{wds_pkg::DIST_W{1'b0}}, lb_q} * {{wds_pkg::DIST_W{1'b0}}, lb_q};
      tinf2_q <= (ta_q == wds_pkg::DIST_MAX) || (tb_q == wds_pkg::DIST_MAX);
      linf2_q <= (la_q == wds_pkg::DIST_MAX) || (lb_q == wds_pkg::DIST_MAX);
      dmin2_q <= (dz_q < dxy) ? dz_q : dxy;
      obst2_q <= obst1_q;
      step2_q <= step1_q;
    end
  end

  // stage 3: sums of squares
  logic [wds_pkg::SQ_W:0]     tsum, lsum;
  logic [wds_pkg::SQ_W-1:0]   ts3_q, ls3_q;
  logic                       tinf3_q, linf3_q, obst3_q, step3_q;
  logic [wds_pkg::DIST_W-1:0] dmin3_q;

  assign tsum = {1'b0, ta2_q} + {1'b0, tb2_q};
  assign lsum = {1'b0, la2_q} + {1'b0, lb2_q};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ts3_q <= tsum[wds_pkg::SQ_W-1:0];
      ls3_q <= lsum[wds_pkg::SQ_W-1:0];
      tinf3_q <= tinf2_q || tsum[wds_pkg::SQ_W];
      linf3_q <= linf2_q || lsum[wds_pkg::SQ_W];
      dmin3_q <= dmin2_q;
      obst3_q <= obst2_q;
      step3_q <= step2_q;
    end
  end

  // square root stages, index 0 is top edge, 1 is left edge
  logic [wds_pkg::REM_W-1:0]  rem_q  [NQ][2];
  logic [wds_pkg::DIST_W-1:0] root_q [NQ][2];
  logic [wds_pkg::SQ_W-1:0]   rad_q  [NQ][2];
  logic [wds_pkg::REM_W-1:0]  rem_d  [NQ][2];
  logic [wds_pkg::DIST_W-1:0] root_d [NQ][2];
  logic [wds_pkg::SQ_W-1:0]   rad_d  [NQ][2];
  logic [wds_pkg::DIST_W-1:0] qdmin_q [NQ];
  logic [NQ-1:0]              qobst_q, qstep_q, qtinf_q, qlinf_q;

  always_comb begin
    logic [wds_pkg::REM_W-1:0]  r;
    logic [wds_pkg::REM_W-1:0]  t;
    logic [wds_pkg::DIST_W-1:0] q;
    logic [wds_pkg::SQ_W-1:0]   v;
    for (int s = 0; s < NQ; s++) begin
      for (int u = 0; u < 2; u++) begin
        if (s == 0) begin
          r = '0;
          q = '0;
          v = (u == 0) ? ts3_q : ls3_q;
        end else begin
          r = rem_q[s-1][u];
          q = root_q[s-1][u];
          v = rad_q[s-1][u];
        end
        for (int b = 0; b < wds_pkg::SQRT_STEPS; b++) begin
          r = {1'b0, r[wds_pkg::REM_W-4:0], v[wds_pkg::SQ_W-1 -: 2]};
          v = {v[wds_pkg::SQ_W-3:0], 2'b00};
          t = {1'b0, q, 2'b01};
          if (r >= t) begin
            r = r - t;
            q = {q[wds_pkg::DIST_W-2:0], 1'b1};
          end else begin
            q = {q[wds_pkg::DIST_W-2:0], 1'b0};
          end
        end
        rem_d[s][u]  = r;
        root_d[s][u] = q;
        rad_d[s][u]  = v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NQ; s++) begin
      if (en[SQB+s]) begin
        for (int u = 0; u < 2; u++) begin
          rem_q[s][u]  <= rem_d[s][u];
          root_q[s][u] <= root_d[s][u];
          rad_q[s][u]  <= rad_d[s][u];
        end
        if (s == 0) begin
          qdmin_q[s] <= dmin3_q;
          qobst_q[s] <= obst3_q;
          qstep_q[s] <= step3_q;
          qtinf_q[s] <= tinf3_q;
          qlinf_q[s] <= linf3_q;
        end else begin
          qdmin_q[s] <= qdmin_q[s-1];
          qobst_q[s] <= qobst_q[s-1];
          qstep_q[s] <= qstep_q[s-1];
          qtinf_q[s] <= qtinf_q[s-1];
          qlinf_q[s] <= qlinf_q[s-1];
        end
      end
    end
  end

  // output stage
  logic [wds_pkg::DIST_W-1:0] top_d, left_d, edge_d, dist_d, dist_q, dmin_out_q;
  logic                       obst_out_q, step_out_q;

  always_comb begin
    top_d  = qtinf_q[NQ-1] ? wds_pkg::DIST_MAX : root_q[NQ-1][0];
    left_d = qlinf_q[NQ-1] ? wds_pkg::DIST_MAX : root_q[NQ-1][1];
    edge_d = (top_d < left_d) ? top_d : left_d;
    dist_d = qdmin_q[NQ-1];
    if (qstep_q[NQ-1] && (edge_d < dist_d)) dist_d = edge_d;
    if (qobst_q[NQ-1]) dist_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      dist_q     <= dist_d;
      dmin_out_q <= qdmin_q[NQ-1];
      obst_out_q <= qobst_q[NQ-1];
      step_out_q <= qstep_q[NQ-1];
    end
  end

  assign out_o.valid     = valid_q[NS-1];
  assign out_o.wall_dist = dist_q;

  a_obst_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && obst_out_q |-> out_o.wall_dist == '0)
    else $error("obstacle cell gave nonzero distance");

  a_not_above_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.wall_dist <= dmin_out_q)
    else $error("distance exceeds axis minimum");

  a_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !obst_out_q && !step_out_q |-> out_o.wall_dist == dmin_out_q)
    else $error("step term used while step disabled");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> valid_q == '0)
    else $error("pipeline not empty after reset");

endmodule

// ----- tb/wds_tb_pkg.sv -----
// Distance predictor and result scoreboard for the wall distance stencil bench.
`timescale 1ns / 1ps
package wds_tb_pkg;
  import wds_pkg::*;

  typedef struct {
    logic [5:0]        walls;
    logic [IDX_W-1:0]  nx, ny, nz;
    logic              depth3;
    logic [IDX_W-1:0]  stx, sty;
  } geom_t;

  typedef struct {
    logic [IDX_W-1:0]  ci, cj, ck;
    logic              obst;
    logic [DIST_W-1:0] wx, wy, wz;
  } cell_t;

  function automatic longint unsigned scaled(int unsigned n, longint unsigned w);
    longint unsigned p;
    p = longint'(n) * w;
    return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
  endfunction

  function automatic int unsigned idiff(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned face_dist(bit lo, bit hi, int unsigned idx,
                                                longint unsigned w, int unsigned sz);
    if (lo && hi) return scaled((2 * idx <= sz) ? idx : idiff(sz, idx), w);
    if (lo) return scaled(idx, w);
    if (hi) return scaled(idiff(sz, idx), w);
    return 64'hFFFF_FFFF;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    for (int s = 31; s >= 0; s--) begin
      b = r | (64'd1 << s);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic longint unsigned hypot_q(longint unsigned a, longint unsigned b);
    longint unsigned s;
    if (a >= 64'hFFFF_FFFF || b >= 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
    s = a * a + b * b;
    if (s < a * a) return 64'hFFFF_FFFF;
    return isqrt(s);
  endfunction

  function automatic logic [DIST_W-1:0] nearest_wall(geom_t g, cell_t c);
    longint unsigned d, t, l;
    int unsigned ox, oy;
    if (c.obst) return '0;
    d = face_dist(g.walls[0], g.walls[1], c.ci, c.wx, g.nx);
    t = face_dist(g.walls[2], g.walls[3], c.cj, c.wy, g.ny);
    if (t < d) d = t;
    if (g.depth3) begin
      t = face_dist(g.walls[4], g.walls[5], c.ck, c.wz, g.nz);
      if (t < d) d = t;
    end
    if (g.stx != 0 && g.sty != 0) begin
      ox = (c.ci > g.stx) ? c.ci - g.stx : 0;
      oy = (c.cj > g.sty) ? c.cj - g.sty : 0;
      t = hypot_q(scaled(ox, c.wx), scaled(idiff(c.cj, g.sty), c.wy));
      l = hypot_q(scaled(idiff(c.ci, g.stx), c.wx), scaled(oy, c.wy));
      if (t < d) d = t;
      if (l < d) d = l;
    end
    return d[DIST_W-1:0];
  endfunction

  class dist_scoreboard;
    logic [DIST_W-1:0] pending[$];
    int errors = 0;

    function void note_cell(geom_t g, cell_t c);
      pending.push_back(nearest_wall(g, c));
    endfunction

    function void check_dist(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: wall_dist mismatch, expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- tb/wall_distance_stencil_tb.sv -----
// Testbench top: drives cells and register writes, checks every distance word.
`timescale 1ns / 1ps
module wall_distance_stencil_tb;
  import wds_pkg::*;
  import wds_tb_pkg::*;

  localparam int LIMIT = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  always #5 clk_i = ~clk_i;

  wds_item_if   in_if();
  wds_result_if out_if();
  wds_cfg_if    cfg_if();

  wall_distance_stencil dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink),
                             .out_o(out_if.source), .cfg_i(cfg_if.sink));

  dist_scoreboard sb = new();
  geom_t geom;
  int idle_pct = 27;
  int hold_off = 0;
  int cycles = 0;

  initial begin
    in_if.valid = 0; in_if.cell_i = 0; in_if.cell_j = 0; in_if.cell_k = 0;
    in_if.is_obstacle = 0; in_if.width_x = 0; in_if.width_y = 0; in_if.width_z = 0;
    cfg_if.valid = 0; cfg_if.index = REG_WALL_ENABLES; cfg_if.data = 0;
    out_if.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_dist(out_if.wall_dist);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 0;
    case (idx)
      REG_WALL_ENABLES: geom.walls = val[5:0];
      REG_CELLS_X:      geom.nx = val[IDX_W-1:0];
      REG_CELLS_Y:      geom.ny = val[IDX_W-1:0];
      REG_CELLS_Z:      geom.nz = val[IDX_W-1:0];
      REG_THREE_DIM:    geom.depth3 = val[0];
      REG_STEP_X_LIMIT: geom.stx = val[IDX_W-1:0];
      default:          geom.sty = val[IDX_W-1:0];
    endcase
  endtask

  task automatic send_cell(cell_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 0;
      @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.cell_i <= c.ci; in_if.cell_j <= c.cj; in_if.cell_k <= c.ck;
    in_if.is_obstacle <= c.obst;
    in_if.width_x <= c.wx; in_if.width_y <= c.wy; in_if.width_z <= c.wz;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_cell(geom, c);
  endtask

  task automatic drain;
    in_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic logic [DIST_W-1:0] rand_width();
    case ($urandom_range(5))
      0: return $urandom;
      1: return '1;
      2: return 0;
      default: return $urandom_range(32'h0004_0000, 32'h0000_4000);
    endcase
  endfunction

  function automatic cell_t rand_cell(int unsigned span);
    cell_t c;
    int unsigned r;
    if ($urandom_range(9) == 0) span = 1023;
    r = $urandom_range(span); c.ci = r[IDX_W-1:0];
    r = $urandom_range(span); c.cj = r[IDX_W-1:0];
    r = $urandom_range(span); c.ck = r[IDX_W-1:0];
    c.obst = ($urandom_range(9) == 0);
    c.wx = rand_width(); c.wy = rand_width(); c.wz = rand_width();
    return c;
  endfunction

  task automatic random_config(int unsigned span);
    write_reg(REG_WALL_ENABLES, $urandom_range(63));
    write_reg(REG_CELLS_X, $urandom_range(span));
    write_reg(REG_CELLS_Y, $urandom_range(span));
    write_reg(REG_CELLS_Z, $urandom_range(span));
    write_reg(REG_THREE_DIM, $urandom_range(1));
    write_reg(REG_STEP_X_LIMIT, ($urandom_range(3) == 0) ? 0 : $urandom_range(span));
    write_reg(REG_STEP_Y_LIMIT, ($urandom_range(3) == 0) ? 0 : $urandom_range(span));
  endtask

  initial begin
    cell_t c;
    int unsigned span;
    geom.walls = 6'h3F; geom.nx = 10'd64; geom.ny = 10'd64; geom.nz = 10'd64;
    geom.depth3 = 0; geom.stx = '0; geom.sty = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset geometry, ties, beyond size, extremes, obstacle
    c = '{ci: 32, cj: 31, ck: 0, obst: 0, wx: 32'h0001_0000, wy: 32'h0001_0000, wz: 0};
    send_cell(c);
    c.ci = 33; c.cj = 1023; send_cell(c);
    c.obst = 1; send_cell(c);
    c = '{ci: 1023, cj: 1023, ck: 1023, obst: 0, wx: '1, wy: '1, wz: '1};
    send_cell(c);
    c.ci = 0; c.cj = 0; c.ck = 0; send_cell(c);
    c = '{ci: 5, cj: 700, ck: 3, obst: 0, wx: 0, wy: 32'h8000_0000, wz: 1};
    send_cell(c);
    drain();
    write_reg(REG_WALL_ENABLES, 0); write_reg(REG_THREE_DIM, 1);
    write_reg(REG_CELLS_X, 0); write_reg(REG_CELLS_Y, 1023); write_reg(REG_CELLS_Z, 1);
    c = '{ci: 3, cj: 3, ck: 3, obst: 0, wx: 32'h0001_0000, wy: 32'h0002_0000, wz: 5};
    send_cell(c);
    drain();
    write_reg(REG_WALL_ENABLES, 6'h2A); send_cell(c);
    c.ck = 0; send_cell(c);
    drain();
    write_reg(REG_WALL_ENABLES, 6'h15); send_cell(c);
    drain();
    write_reg(REG_STEP_X_LIMIT, 10); write_reg(REG_STEP_Y_LIMIT, 0);
    write_reg(REG_WALL_ENABLES, 0);
    c = '{ci: 15, cj: 20, ck: 0, obst: 0, wx: 32'h0001_0000, wy: 32'h0001_0000, wz: 0};
    send_cell(c);
    drain();
    write_reg(REG_STEP_Y_LIMIT, 12);
    send_cell(c);
    c.ci = 4; c.cj = 30; send_cell(c);
    c.ci = 10; c.cj = 12; send_cell(c);
    c.wx = '1; send_cell(c);
    c.wx = 32'hFFFF_0000; c.wy = 32'hFFFF_0000; c.ci = 1023; c.cj = 1023; send_cell(c);
    drain();
    write_reg(REG_STEP_X_LIMIT, 1023); write_reg(REG_STEP_Y_LIMIT, 1023);
    c = '{ci: 0, cj: 0, ck: 0, obst: 0, wx: 32'h0000_0100, wy: 32'h0000_0200, wz: 0};
    send_cell(c);
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      span = (ph % 3 == 0) ? 1023 : 80;
      random_config(span);
      if (ph == 4) idle_pct = 0;
      if (ph == 5) idle_pct = 27;
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 10) hold_off = 120;
        send_cell(rand_cell(span + 8));
      end
      drain();
    end

    write_reg(REG_WALL_ENABLES, 63); write_reg(REG_CELLS_X, 1); write_reg(REG_CELLS_Y, 1);
    write_reg(REG_CELLS_Z, 1); write_reg(REG_THREE_DIM, 0);
    write_reg(REG_STEP_X_LIMIT, 0); write_reg(REG_STEP_Y_LIMIT, 0);
    for (int n = 0; n < 20; n++) send_cell(rand_cell(3));
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- wall_distance_stencil.f -----
src/wds_pkg.sv
src/wds_if.sv
src/wall_distance_stencil.sv
tb/wds_tb_pkg.sv
tb/wall_distance_stencil_tb.sv
